// ===== rtl/pbob_pkg.sv =====
// Shared constants, types and helpers for the progress bar overlay blend.
package pbob_pkg;

  // Frame geometry limits
  localparam int unsigned MAX_FRAME_DIM = 4096;
  localparam int unsigned DIM_W         = $clog2(MAX_FRAME_DIM) + 1;
  localparam int unsigned POS_W         = $clog2(MAX_FRAME_DIM);
  localparam int unsigned SIDE_DIV      = 20;

  // Side = (min >> 2) / 5, done as a multiply by 3277 / 2^14
  localparam int unsigned QUARTER_W   = DIM_W - 2;
  localparam int unsigned RECIP_W     = 12;
  localparam int unsigned RECIP_SHIFT = 14;
  localparam int unsigned RECIP_MUL   = ((1 << RECIP_SHIFT) + (SIDE_DIV / 4) - 1) / (SIDE_DIV / 4);
  localparam int unsigned SIDE_W      = 8;

  // Fixed point widths
  localparam int unsigned CHAN_W  = 8;
  localparam int unsigned TIME_W  = 17;
  localparam int unsigned ALPHA_W = 9;
  localparam int unsigned PROD_W  = 16;
  localparam int unsigned CFG_W   = 17;
  localparam int unsigned CFG_IDX_W = 3;

  localparam logic [TIME_W-1:0]  TIME_ONE  = TIME_W'(65536);
  localparam logic [ALPHA_W-1:0] ALPHA_ONE = ALPHA_W'(256);

  // Register indexes of the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_WIDTH  = 3'd0,
    CFG_FRAME_HEIGHT = 3'd1,
    CFG_TIME_LEVEL   = 3'd2,
    CFG_BAR_RED      = 3'd3,
    CFG_BAR_GREEN    = 3'd4,
    CFG_BAR_BLUE     = 3'd5,
    CFG_TRANSPARENCY = 3'd6
  } cfg_reg_t;

  // Derived bar geometry and blend weights, all registered
  typedef struct packed {
    logic [ALPHA_W-1:0] tr;        // pixel weight (256 - f)
    logic [PROD_W-1:0]  fc_red;    // f * bar colour
    logic [PROD_W-1:0]  fc_green;
    logic [PROD_W-1:0]  fc_blue;
    logic [DIM_W-1:0]   x0;        // first bar column
    logic [DIM_W-1:0]   x_end;     // one past the last bar column
    logic [DIM_W-1:0]   y0;        // bottom bar row
    logic [SIDE_W-1:0]  count;     // rows filled upward from y0
    logic               side_nz;
  } geom_t;

  // Stage load enables from the handshake control
  typedef struct packed {
    logic load_in;
    logic load_mid;
    logic load_out;
  } pipe_ctl_t;

  // Out-of-range dimensions: zero acts as one, large values saturate
  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] r;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (v > DIM_W'(MAX_FRAME_DIM)) begin
      r = DIM_W'(MAX_FRAME_DIM);
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

// ===== rtl/pbob_config.sv =====
// Configuration registers and the two-stage derivation of bar geometry.
module pbob_config (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [pbob_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [pbob_pkg::CFG_W-1:0]          cfg_data,
  output logic [pbob_pkg::DIM_W-1:0]          width_dim,
  output logic [pbob_pkg::DIM_W-1:0]          height_dim,
  output pbob_pkg::geom_t                     geom
);

  logic [pbob_pkg::DIM_W-1:0]   frame_width;
  logic [pbob_pkg::DIM_W-1:0]   frame_height;
  logic [pbob_pkg::TIME_W-1:0]  time_level;
  logic [pbob_pkg::CHAN_W-1:0]  bar_red;
  logic [pbob_pkg::CHAN_W-1:0]  bar_green;
  logic [pbob_pkg::CHAN_W-1:0]  bar_blue;
  logic [pbob_pkg::ALPHA_W-1:0] transparency;

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= pbob_pkg::DIM_W'(640);
      frame_height <= pbob_pkg::DIM_W'(480);
      time_level   <= '0;
      bar_red      <= '0;
      bar_green    <= '0;
      bar_blue     <= '0;
      transparency <= '0;
    end else if (cfg_write) begin
      case (pbob_pkg::cfg_reg_t'(cfg_index))
        pbob_pkg::CFG_FRAME_WIDTH:  frame_width  <= cfg_data[pbob_pkg::DIM_W-1:0];
        pbob_pkg::CFG_FRAME_HEIGHT: frame_height <= cfg_data[pbob_pkg::DIM_W-1:0];
        pbob_pkg::CFG_TIME_LEVEL:   time_level   <= cfg_data[pbob_pkg::TIME_W-1:0];
        pbob_pkg::CFG_BAR_RED:      bar_red      <= cfg_data[pbob_pkg::CHAN_W-1:0];
        pbob_pkg::CFG_BAR_GREEN:    bar_green    <= cfg_data[pbob_pkg::CHAN_W-1:0];
        pbob_pkg::CFG_BAR_BLUE:     bar_blue     <= cfg_data[pbob_pkg::CHAN_W-1:0];
        pbob_pkg::CFG_TRANSPARENCY: transparency <= cfg_data[pbob_pkg::ALPHA_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamped dimensions feed the raster counters directly
  assign width_dim  = pbob_pkg::clamp_dim(frame_width);
  assign height_dim = pbob_pkg::clamp_dim(frame_height);

  // First derivation stage: side, weights, remaining time
  logic [pbob_pkg::DIM_W-1:0]     min_dim;
  logic [pbob_pkg::QUARTER_W-1:0] quarter;
  logic [pbob_pkg::QUARTER_W+pbob_pkg::RECIP_W-1:0] side_prod;
  logic [pbob_pkg::ALPHA_W-1:0]   tr_sat;
  logic [pbob_pkg::ALPHA_W-1:0]   f_weight;
  logic [pbob_pkg::TIME_W-1:0]    t_sat;
  logic [pbob_pkg::PROD_W:0]      fcr_full;
  logic [pbob_pkg::PROD_W:0]      fcg_full;
  logic [pbob_pkg::PROD_W:0]      fcb_full;

  assign min_dim   = (width_dim < height_dim) ? width_dim : height_dim;
  assign quarter   = min_dim[pbob_pkg::DIM_W-1:2];
  assign side_prod = (pbob_pkg::QUARTER_W+pbob_pkg::RECIP_W)'(quarter)
                   * (pbob_pkg::QUARTER_W+pbob_pkg::RECIP_W)'(pbob_pkg::RECIP_MUL);
  assign tr_sat    = (transparency > pbob_pkg::ALPHA_ONE) ? pbob_pkg::ALPHA_ONE : transparency;
  assign f_weight  = pbob_pkg::ALPHA_ONE - tr_sat;
  assign t_sat     = (time_level > pbob_pkg::TIME_ONE) ? pbob_pkg::TIME_ONE : time_level;
  assign fcr_full  = (pbob_pkg::PROD_W+1)'(f_weight) * (pbob_pkg::PROD_W+1)'(bar_red);
  assign fcg_full  = (pbob_pkg::PROD_W+1)'(f_weight) * (pbob_pkg::PROD_W+1)'(bar_green);
  assign fcb_full  = (pbob_pkg::PROD_W+1)'(f_weight) * (pbob_pkg::PROD_W+1)'(bar_blue);

  logic [pbob_pkg::DIM_W-1:0]  w1;
  logic [pbob_pkg::DIM_W-1:0]  h1;
  logic [pbob_pkg::SIDE_W-1:0] side1;
  logic [pbob_pkg::TIME_W-1:0] rem1;

  always_ff @(posedge clk) begin
    w1            <= width_dim;
    h1            <= height_dim;
    side1         <= side_prod[pbob_pkg::RECIP_SHIFT+pbob_pkg::SIDE_W-1:pbob_pkg::RECIP_SHIFT];
    rem1          <= pbob_pkg::TIME_ONE - t_sat;
    geom.tr       <= tr_sat;
    geom.fc_red   <= fcr_full[pbob_pkg::PROD_W-1:0];
    geom.fc_green <= fcg_full[pbob_pkg::PROD_W-1:0];
    geom.fc_blue  <= fcb_full[pbob_pkg::PROD_W-1:0];
  end

  // Second derivation stage: bar edges and filled row count (rounded up)
  localparam int unsigned CNT_W = pbob_pkg::TIME_W + pbob_pkg::SIDE_W;
  logic [CNT_W-1:0] count_prod;
  logic [CNT_W:0]   count_sum;

  assign count_prod = CNT_W'(rem1) * CNT_W'(side1);
  assign count_sum  = (CNT_W+1)'(count_prod) + (CNT_W+1)'(16'hFFFF);

  always_ff @(posedge clk) begin
    geom.x0      <= w1 - {side1, 1'b0};
    geom.x_end   <= w1 - pbob_pkg::DIM_W'(side1);
    geom.y0      <= h1 - pbob_pkg::DIM_W'(side1);
    geom.count   <= count_sum[pbob_pkg::TIME_W-1+pbob_pkg::SIDE_W-1:pbob_pkg::TIME_W-1];
    geom.side_nz <= (side1 != '0);
  end

endmodule

// ===== rtl/pbob_raster.sv =====
// Raster position counters: column and row of each accepted pixel.
module pbob_raster (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          accept,
  input  logic                          frame_start,
  input  logic [pbob_pkg::DIM_W-1:0]    width_dim,
  input  logic [pbob_pkg::DIM_W-1:0]    height_dim,
  output logic [pbob_pkg::POS_W-1:0]    pos_col,
  output logic [pbob_pkg::POS_W-1:0]    pos_row
);

  logic [pbob_pkg::POS_W-1:0] column_count;
  logic [pbob_pkg::POS_W-1:0] row_count;
  logic [pbob_pkg::POS_W-1:0] column_count_next;
  logic [pbob_pkg::POS_W-1:0] row_count_next;
  logic [pbob_pkg::DIM_W-1:0] col_inc;
  logic [pbob_pkg::DIM_W-1:0] row_inc;

  // Frame start forces the current word to the origin
  assign pos_col = frame_start ? '0 : column_count;
  assign pos_row = frame_start ? '0 : row_count;

  assign col_inc = pbob_pkg::DIM_W'(pos_col) + pbob_pkg::DIM_W'(1);
  assign row_inc = pbob_pkg::DIM_W'(pos_row) + pbob_pkg::DIM_W'(1);

  // Advance with wrap at end of line and end of frame
  always_comb begin
    if (col_inc >= width_dim) begin
      column_count_next = '0;
      row_count_next    = (row_inc >= height_dim) ? '0 : row_inc[pbob_pkg::POS_W-1:0];
    end else begin
      column_count_next = col_inc[pbob_pkg::POS_W-1:0];
      row_count_next    = pos_row;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (accept) begin
      column_count <= column_count_next;
      row_count    <= row_count_next;
    end
  end

endmodule

// ===== rtl/pbob_blend.sv =====
// Three-stage datapath: input register, weighted pixel products, blended output.
module pbob_blend (
  input  logic                          clk,
  input  pbob_pkg::pipe_ctl_t           ctl,
  input  pbob_pkg::geom_t               geom,
  input  logic [pbob_pkg::CHAN_W-1:0]   pixel_red,
  input  logic [pbob_pkg::CHAN_W-1:0]   pixel_green,
  input  logic [pbob_pkg::CHAN_W-1:0]   pixel_blue,
  input  logic [pbob_pkg::CHAN_W-1:0]   pixel_alpha,
  input  logic [pbob_pkg::POS_W-1:0]    pos_col,
  input  logic [pbob_pkg::POS_W-1:0]    pos_row,
  output logic [pbob_pkg::CHAN_W-1:0]   out_red,
  output logic [pbob_pkg::CHAN_W-1:0]   out_green,
  output logic [pbob_pkg::CHAN_W-1:0]   out_blue,
  output logic [pbob_pkg::CHAN_W-1:0]   out_alpha
);

  // Input register
  logic [pbob_pkg::CHAN_W-1:0] r1, g1, b1, a1;
  logic [pbob_pkg::POS_W-1:0]  col1, row1;

  always_ff @(posedge clk) begin
    if (ctl.load_in) begin
      r1   <= pixel_red;
      g1   <= pixel_green;
      b1   <= pixel_blue;
      a1   <= pixel_alpha;
      col1 <= pos_col;
      row1 <= pos_row;
    end
  end

  // Pixel weight products
  logic [pbob_pkg::PROD_W:0] pr_full, pg_full, pb_full;

  assign pr_full = (pbob_pkg::PROD_W+1)'(geom.tr) * (pbob_pkg::PROD_W+1)'(r1);
  assign pg_full = (pbob_pkg::PROD_W+1)'(geom.tr) * (pbob_pkg::PROD_W+1)'(g1);
  assign pb_full = (pbob_pkg::PROD_W+1)'(geom.tr) * (pbob_pkg::PROD_W+1)'(b1);

  logic [pbob_pkg::CHAN_W-1:0] r2, g2, b2, a2;
  logic [pbob_pkg::PROD_W-1:0] pr2, pg2, pb2;
  logic [pbob_pkg::POS_W-1:0]  col2, row2;

  always_ff @(posedge clk) begin
    if (ctl.load_mid) begin
      r2   <= r1;
      g2   <= g1;
      b2   <= b1;
      a2   <= a1;
      pr2  <= pr_full[pbob_pkg::PROD_W-1:0];
      pg2  <= pg_full[pbob_pkg::PROD_W-1:0];
      pb2  <= pb_full[pbob_pkg::PROD_W-1:0];
      col2 <= col1;
      row2 <= row1;
    end
  end

  // Bar hit test and final blend
  logic [pbob_pkg::DIM_W-1:0] col_ext;
  logic [pbob_pkg::DIM_W-1:0] row_ext;
  logic [pbob_pkg::DIM_W-1:0] row_top;
  logic                       hit;
  logic [pbob_pkg::PROD_W:0]  sum_r, sum_g, sum_b;

  assign col_ext = pbob_pkg::DIM_W'(col2);
  assign row_ext = pbob_pkg::DIM_W'(row2);
  assign row_top = row_ext + pbob_pkg::DIM_W'(geom.count);
  assign hit     = geom.side_nz
                && (col_ext >= geom.x0) && (col_ext < geom.x_end)
                && (row_ext <= geom.y0) && (row_top > geom.y0);

  assign sum_r = (pbob_pkg::PROD_W+1)'(geom.fc_red)   + (pbob_pkg::PROD_W+1)'(pr2);
  assign sum_g = (pbob_pkg::PROD_W+1)'(geom.fc_green) + (pbob_pkg::PROD_W+1)'(pg2);
  assign sum_b = (pbob_pkg::PROD_W+1)'(geom.fc_blue)  + (pbob_pkg::PROD_W+1)'(pb2);

  always_ff @(posedge clk) begin
    if (ctl.load_out) begin
      out_red   <= hit ? sum_r[pbob_pkg::PROD_W-1:pbob_pkg::CHAN_W] : r2;
      out_green <= hit ? sum_g[pbob_pkg::PROD_W-1:pbob_pkg::CHAN_W] : g2;
      out_blue  <= hit ? sum_b[pbob_pkg::PROD_W-1:pbob_pkg::CHAN_W] : b2;
      out_alpha <= a2;
    end
  end

endmodule

// ===== rtl/progress_bar_overlay_blend.sv =====
// Top level: progress bar overlay blend with valid/stall channels.
//
//   Channel  Direction  Handshake             Payload
//   input    in         in_valid / in_stall   pixel_red/green/blue/alpha, frame_start
//   output   out        out_valid / out_stall out_red/green/blue/alpha
//   config   in         cfg_write             cfg_index, cfg_data
//
// One word per clock sustained while out_stall is low; an accepted word passes the input register,
// the product register and the output register before it is shown with out_valid.
// Register writes reach the blend path through a two-stage geometry pipeline that
// stays ahead of any word accepted after the write.
// Reset is synchronous; in_stall is held high while rst is asserted.
// A stalled output keeps its word; up to two more words are taken before in_stall rises.
module progress_bar_overlay_blend (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [pbob_pkg::CHAN_W-1:0]       pixel_red,
  input  logic [pbob_pkg::CHAN_W-1:0]       pixel_green,
  input  logic [pbob_pkg::CHAN_W-1:0]       pixel_blue,
  input  logic [pbob_pkg::CHAN_W-1:0]       pixel_alpha,
  input  logic                              frame_start,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [pbob_pkg::CHAN_W-1:0]       out_red,
  output logic [pbob_pkg::CHAN_W-1:0]       out_green,
  output logic [pbob_pkg::CHAN_W-1:0]       out_blue,
  output logic [pbob_pkg::CHAN_W-1:0]       out_alpha,
  input  logic                              cfg_write,
  input  logic [pbob_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [pbob_pkg::CFG_W-1:0]        cfg_data
);

  logic [pbob_pkg::DIM_W-1:0] width_dim;
  logic [pbob_pkg::DIM_W-1:0] height_dim;
  pbob_pkg::geom_t            geom;
  logic [pbob_pkg::POS_W-1:0] pos_col;
  logic [pbob_pkg::POS_W-1:0] pos_row;
  pbob_pkg::pipe_ctl_t        ctl;

  // Stage occupancy
  logic vld_in;
  logic vld_mid;
  logic rdy_in, rdy_mid, rdy_out;
  logic in_accept;

  assign rdy_out   = !out_valid || !out_stall;
  assign rdy_mid   = !vld_mid || rdy_out;
  assign rdy_in    = !vld_in || rdy_mid;
  assign in_stall  = rst || !rdy_in;
  assign in_accept = in_valid && !in_stall;

  assign ctl.load_in  = in_accept;
  assign ctl.load_mid = rdy_mid && vld_in;
  assign ctl.load_out = rdy_out && vld_mid;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_in    <= 1'b0;
      vld_mid   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (rdy_in) begin
        vld_in <= in_valid;
      end
      if (rdy_mid) begin
        vld_mid <= vld_in;
      end
      if (rdy_out) begin
        out_valid <= vld_mid;
      end
    end
  end

  pbob_config u_config (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .width_dim  (width_dim),
    .height_dim (height_dim),
    .geom       (geom)
  );

  pbob_raster u_raster (
    .clk         (clk),
    .rst         (rst),
    .accept      (in_accept),
    .frame_start (frame_start),
    .width_dim   (width_dim),
    .height_dim  (height_dim),
    .pos_col     (pos_col),
    .pos_row     (pos_row)
  );

  pbob_blend u_blend (
    .clk         (clk),
    .ctl         (ctl),
    .geom        (geom),
    .pixel_red   (pixel_red),
    .pixel_green (pixel_green),
    .pixel_blue  (pixel_blue),
    .pixel_alpha (pixel_alpha),
    .pos_col     (pos_col),
    .pos_row     (pos_row),
    .out_red     (out_red),
    .out_green   (out_green),
    .out_blue    (out_blue),
    .out_alpha   (out_alpha)
  );

  // Input only stalls when every stage is full and the output is held
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (vld_in && vld_mid && out_valid && out_stall))
    else $error("input stalled with a free stage");

  // An accepted word lands in the input stage
  a_accept_fills: assert property (@(posedge clk) disable iff (rst)
    in_accept |=> vld_in)
    else $error("accepted word lost from input stage");

  // A middle word with room ahead reaches the output next cycle
  a_mid_advances: assert property (@(posedge clk) disable iff (rst)
    (vld_mid && rdy_out) |=> out_valid)
    else $error("middle stage word did not advance");

endmodule

// ===== sim/progress_bar_overlay_blend_tb.sv =====
// Testbench for progress_bar_overlay_blend: random pixel streams checked against a bar predictor.
`timescale 1ns / 1ps

module progress_bar_overlay_blend_tb;
  import pbob_pkg::*;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
    logic [CHAN_W-1:0] alpha;
  } rgba_t;

  // Tracks raster position and register state, queues the blended pixel per word
  class blend_scoreboard;
    bit [12:0]   width_reg;
    bit [12:0]   height_reg;
    bit [16:0]   time_reg;
    bit [7:0]    red_reg;
    bit [7:0]    green_reg;
    bit [7:0]    blue_reg;
    bit [8:0]    transp_reg;
    bit [11:0]   column;
    bit [11:0]   row;
    rgba_t       blended_q[$];
    int unsigned errors;

    function new();
      width_reg  = 640;
      height_reg = 480;
      time_reg   = 0;
      red_reg    = 0;
      green_reg  = 0;
      blue_reg   = 0;
      transp_reg = 0;
      column     = 0;
      row        = 0;
      errors     = 0;
    endfunction

    function void set_register(cfg_reg_t idx, int unsigned value);
      case (idx)
        CFG_FRAME_WIDTH:  width_reg  = value[12:0];
        CFG_FRAME_HEIGHT: height_reg = value[12:0];
        CFG_TIME_LEVEL:   time_reg   = value[16:0];
        CFG_BAR_RED:      red_reg    = value[7:0];
        CFG_BAR_GREEN:    green_reg  = value[7:0];
        CFG_BAR_BLUE:     blue_reg   = value[7:0];
        CFG_TRANSPARENCY: transp_reg = value[8:0];
        default: ;
      endcase
    endfunction

    // Clamped frame size and bar placement for a given register setting
    function void bar_geometry(input int unsigned wr, hr, time_in,
                               output int unsigned w, h, side, x0, y0, count);
      int unsigned t;
      w = (wr == 0) ? 1 : ((wr > MAX_FRAME_DIM) ? MAX_FRAME_DIM : wr);
      h = (hr == 0) ? 1 : ((hr > MAX_FRAME_DIM) ? MAX_FRAME_DIM : hr);
      side  = ((w < h) ? w : h) / SIDE_DIV;
      x0    = w - 2 * side;
      y0    = h - side;
      t     = (time_in > TIME_ONE) ? TIME_ONE : time_in;
      // rows filled = ceil((1 - time) * side)
      count = ((TIME_ONE - t) * side + TIME_ONE - 1) >> 16;
    endfunction

    function bit [7:0] mix_channel(int unsigned f, bit [7:0] colour, bit [7:0] pix);
      return 8'((f * colour + (ALPHA_ONE - f) * pix) >> 8);
    endfunction

    function void note_pixel(rgba_t px, bit fs);
      int unsigned w, h, side, x0, y0, count, f;
      bit          hit;
      rgba_t       res;
      bar_geometry(width_reg, height_reg, time_reg, w, h, side, x0, y0, count);
      f = ALPHA_ONE - ((transp_reg > ALPHA_ONE) ? ALPHA_ONE : transp_reg);
      if (fs) begin
        column = 0;
        row    = 0;
      end
      hit = side != 0 && column >= x0 && column < x0 + side &&
            row <= y0 && row + count > y0;
      res = px;
      if (hit) begin
        res.red   = mix_channel(f, red_reg, px.red);
        res.green = mix_channel(f, green_reg, px.green);
        res.blue  = mix_channel(f, blue_reg, px.blue);
      end
      blended_q.push_back(res);
      // raster advance; a position past a shrunk frame wraps here
      if (column + 1 >= w) begin
        column = 0;
        row    = (row + 1 >= h) ? 12'd0 : row + 1;
      end else begin
        column = column + 1;
      end
    endfunction

    function void compare_channel(string name, logic [7:0] want, logic [7:0] got);
      if (want !== got) begin
        $error("%s mismatch: expected %0d, got %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(rgba_t got);
      rgba_t want;
      if (blended_q.size() == 0) begin
        $error("output word with no pixel pending: %h", got);
        errors++;
        return;
      end
      want = blended_q.pop_front();
      compare_channel("out_red", want.red, got.red);
      compare_channel("out_green", want.green, got.green);
      compare_channel("out_blue", want.blue, got.blue);
      compare_channel("out_alpha", want.alpha, got.alpha);
    endfunction

    function int unsigned pending();
      return blended_q.size();
    endfunction
  endclass

  logic              clk;
  logic              rst;
  logic              in_valid;
  logic              in_stall;
  logic [CHAN_W-1:0] pixel_red;
  logic [CHAN_W-1:0] pixel_green;
  logic [CHAN_W-1:0] pixel_blue;
  logic [CHAN_W-1:0] pixel_alpha;
  logic              frame_start;
  logic              out_valid;
  logic              out_stall;
  logic [CHAN_W-1:0] out_red;
  logic [CHAN_W-1:0] out_green;
  logic [CHAN_W-1:0] out_blue;
  logic [CHAN_W-1:0] out_alpha;
  logic              cfg_write;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]  cfg_data;

  blend_scoreboard sb = new();
  bit              steady;
  int unsigned     pixels_sent;

  progress_bar_overlay_blend uut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .pixel_red   (pixel_red),
    .pixel_green (pixel_green),
    .pixel_blue  (pixel_blue),
    .pixel_alpha (pixel_alpha),
    .frame_start (frame_start),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_red     (out_red),
    .out_green   (out_green),
    .out_blue    (out_blue),
    .out_alpha   (out_alpha),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Mostly short gaps, now and then a long one
  function automatic int unsigned idle_length();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic rgba_t random_pixel();
    rgba_t p;
    p.red   = $urandom_range(0, 255);
    p.green = $urandom_range(0, 255);
    p.blue  = $urandom_range(0, 255);
    p.alpha = $urandom_range(0, 255);
    return p;
  endfunction

  // Output side back-pressure: bursts of stall between runs of ready cycles
  initial begin
    int unsigned stall_left;
    int unsigned run_left;
    stall_left = 0;
    run_left   = 0;
    out_stall  = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left == 0 && run_left == 0) begin
        stall_left = idle_length();
        run_left   = $urandom_range(1, 12);
      end
      if (!steady && stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
        if (run_left > 0) run_left--;
      end
    end
  end

  // Every accepted output word is checked against the oldest prediction
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      sb.check_result({out_red, out_green, out_blue, out_alpha});
  end

  task automatic send_pixel(input rgba_t px, input bit fs);
    int unsigned gap;
    gap = steady ? 0 : idle_length();
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid    <= 1'b1;
    pixel_red   <= px.red;
    pixel_green <= px.green;
    pixel_blue  <= px.blue;
    pixel_alpha <= px.alpha;
    frame_start <= fs;
    do begin
      @(posedge clk);
    end while (in_stall);
    sb.note_pixel(px, fs);
    pixels_sent++;
  endtask

  // Wait until every word in flight has come out, plus the pipeline depth
  task automatic drain_pipe();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_register(input cfg_reg_t idx, input int unsigned value);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_W'(value);
    sb.set_register(idx, value);
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  // One setting: program registers, walk down to just above the bar with a
  // one-pixel-wide frame, then restore the width and stream across the bar
  task automatic run_phase(input int unsigned wv, hv, tv, rv, gv, bv, trv,
                           input bit resume);
    int unsigned w, h, side, x0, y0, count;
    int          target;
    int          n;
    drain_pipe();
    steady = ($urandom_range(0, 3) == 0);
    write_register(CFG_FRAME_HEIGHT, hv);
    write_register(CFG_TIME_LEVEL, tv);
    write_register(CFG_BAR_RED, rv);
    write_register(CFG_BAR_GREEN, gv);
    write_register(CFG_BAR_BLUE, bv);
    write_register(CFG_TRANSPARENCY, trv);
    sb.bar_geometry(wv, hv, tv, w, h, side, x0, y0, count);
    target = 0;
    if (!resume) begin
      if (side == 0) begin
        target = $urandom_range(0, (h > 30) ? 30 : h - 1);
      end else begin
        target = int'(y0) + 1 - int'(count) - ((w <= 200) ? int'($urandom_range(0, 1)) : 0);
        if (target > int'(y0)) target = int'(y0);
        if (target < 0 || target > 600) target = 0;
      end
    end
    if (target > 0) begin
      write_register(CFG_FRAME_WIDTH, 1);
      for (int i = 0; i < target; i++) send_pixel(random_pixel(), i == 0);
      drain_pipe();
    end
    write_register(CFG_FRAME_WIDTH, wv);
    if (resume || side == 0 || (target == 0 && y0 > 600))
      n = (2 * w > 400) ? 400 : 2 * w;
    else
      n = (int'(y0) - target) * int'(w) + int'(x0 + side) +
          int'($urandom_range(1, (w > 32) ? 32 : w));
    // occasional stray frame_start as noise
    for (int i = 0; i < n; i++)
      send_pixel(random_pixel(),
                 (i == 0 && target == 0 && !resume) || $urandom_range(0, 399) == 0);
  endtask

  // Stimulus
  initial begin
    int unsigned base;
    int unsigned wv, hv, tv, trv;
    rgba_t       px;
    rst         = 1'b1;
    in_valid    = 1'b0;
    pixel_red   = '0;
    pixel_green = '0;
    pixel_blue  = '0;
    pixel_alpha = '0;
    frame_start = 1'b0;
    cfg_write   = 1'b0;
    cfg_index   = CFG_FRAME_WIDTH;
    cfg_data    = '0;
    steady      = 1'b0;
    pixels_sent = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // channel extremes under the reset geometry, with frame starts
    for (int i = 0; i < 8; i++) begin
      px.red   = i[0] ? 8'hFF : 8'h00;
      px.green = i[1] ? 8'hFF : 8'h00;
      px.blue  = i[2] ? 8'hFF : 8'h00;
      px.alpha = (i == 3 || i == 6) ? 8'hFF : 8'h00;
      send_pixel(px, (i % 3) == 0);
    end

    // corner settings: opaque minimal bar, width above max and fully transparent,
    // zero width with saturated time and transparency, empty bar, height at max,
    // a one-line frame, then a narrower frame picked up mid-line
    run_phase(20, 20, 0, 255, 0, 128, 0, 1'b0);
    run_phase(8191, 20, 65535, 17, 200, 99, 256, 1'b0);
    run_phase(0, 8191, 131071, 255, 255, 255, 511, 1'b0);
    run_phase(40, 45, 65536, 0, 255, 0, 100, 1'b0);
    run_phase(20, 4096, 1, 90, 30, 250, 255, 1'b0);
    run_phase(64, 0, 32768, 5, 6, 7, 1, 1'b0);
    run_phase(25, 30, 0, 200, 100, 50, 128, 1'b1);
    run_phase(100, 100, 6554, 1, 254, 77, 64, 1'b0);

    // random settings until enough words have gone through
    base = pixels_sent;
    while (pixels_sent - base < 1050) begin
      wv  = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 19) : $urandom_range(20, 100);
      hv  = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 19) : $urandom_range(20, 100);
      case ($urandom_range(0, 5))
        0:       tv = 0;
        1:       tv = 65536;
        2:       tv = $urandom_range(65537, 131071);
        default: tv = $urandom_range(0, 65536);
      endcase
      case ($urandom_range(0, 5))
        0:       trv = 0;
        1:       trv = 256;
        2:       trv = $urandom_range(257, 511);
        default: trv = $urandom_range(0, 256);
      endcase
      run_phase(wv, hv, tv, $urandom_range(0, 255), $urandom_range(0, 255),
                $urandom_range(0, 255), trv, $urandom_range(0, 4) == 0);
    end

    drain_pipe();
    repeat (8) @(posedge clk);
    if (sb.errors == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

  // Watchdog
  initial begin
    #50_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
